>>> rtl/core/mpbm_pkg.sv
// shared constants, codes and types of the multi-pattern byte matcher
// used by the channel interfaces and every module under rtl/core except mpbm_queue
package mpbm_pkg;

  // default sizes, overridable through the top level parameters
  localparam int unsigned PATTERNS_DEF = 8;
  localparam int unsigned MAX_LEN_DEF  = 32;

  // results per scanned byte are capped at this count
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS);

  // entries in the queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // field widths of the channels
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HIT_W      = 3;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BYTE = 2'd0,
    OP_SET_LEN   = 2'd1,
    OP_SCAN      = 2'd2,
    OP_NEW_BUF   = 2'd3
  } op_e;

  // the unnamed fourth code behaves as every-match
  typedef enum logic [MODE_W-1:0] {
    MODE_EVERY   = 2'd0,
    MODE_SEGMENT = 2'd1,
    MODE_FIRST   = 2'd2
  } report_mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENSITIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MODE    = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_NL      = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CASE_DELTA   = 8'h20;

  localparam logic [CNT_W-1:0] LINE_FIRST = 32'd1;

  // counters of one scanned byte, taken before that byte is counted
  typedef struct packed {
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] line;
  } scan_info_t;

  // width of a pattern length 0..max_len
  function automatic int unsigned len_width(int unsigned max_len);
    return $clog2(max_len + 1);
  endfunction

  // width of a window position, also the modulus of the stored line tags
  function automatic int unsigned idx_width(int unsigned max_len);
    return (max_len > 1) ? $clog2(max_len) : 1;
  endfunction

  function automatic int unsigned pat_width(int unsigned patterns);
    return (patterns > 1) ? $clog2(patterns) : 1;
  endfunction

endpackage

>>> rtl/core/mpbm_if.sv
// valid/ready channel interfaces of the multi-pattern byte matcher
// depends on mpbm_pkg for field widths
interface mpbm_in_if;
  logic                              valid;
  logic                              ready;
  logic [mpbm_pkg::OP_W-1:0]         op;
  logic [mpbm_pkg::SLOT_W-1:0]       pattern_slot;
  logic [mpbm_pkg::POS_W-1:0]        byte_position;
  logic [mpbm_pkg::BYTE_W-1:0]       value;

  modport source (output valid, op, pattern_slot, byte_position, value, input ready);
  modport sink (input valid, op, pattern_slot, byte_position, value, output ready);
endinterface

interface mpbm_out_if;
  logic                              valid;
  logic                              ready;
  logic [mpbm_pkg::HIT_W-1:0]        pattern_hit;
  logic [mpbm_pkg::CNT_W-1:0]        start_offset;
  logic [mpbm_pkg::CNT_W-1:0]        line_number;
  logic                              last_of_run;

  modport source (output valid, pattern_hit, start_offset, line_number, last_of_run,
                  input ready);
  modport sink (input valid, pattern_hit, start_offset, line_number, last_of_run,
                output ready);
endinterface

>>> rtl/core/mpbm_front.sv
// front end: takes input transfers, holds patterns, window and counters,
// compares all patterns in one stage and pushes filtered hits; uses mpbm_pkg, mpbm_if
module mpbm_front #(
  parameter int unsigned PATTERNS = mpbm_pkg::PATTERNS_DEF,
  parameter int unsigned MAX_LEN  = mpbm_pkg::MAX_LEN_DEF,
  localparam int unsigned LENW    = mpbm_pkg::len_width(MAX_LEN),
  localparam int unsigned IDXW    = mpbm_pkg::idx_width(MAX_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              case_sensitive_i,
  input  logic [mpbm_pkg::MODE_W-1:0]       report_mode_i,
  mpbm_in_if.sink                           item_i,
  input  logic                              q_ready_i,
  output logic                              push_valid_o,
  output logic [PATTERNS-1:0]               push_hits_o,
  output logic [PATTERNS-1:0][LENW-1:0]     push_len_o,
  output logic [PATTERNS-1:0][IDXW-1:0]     push_nl_o,
  output mpbm_pkg::scan_info_t              push_info_o
);

  localparam int unsigned BYTE_W = mpbm_pkg::BYTE_W;
  localparam int unsigned CNT_W  = mpbm_pkg::CNT_W;

  function automatic logic [BYTE_W-1:0] fold(logic [BYTE_W-1:0] c, logic cs);
    if (!cs && c >= mpbm_pkg::CHAR_UPPER_A && c <= mpbm_pkg::CHAR_UPPER_Z) begin
      return c + mpbm_pkg::CASE_DELTA;
    end
    return c;
  endfunction

  logic [BYTE_W-1:0] pat_q [PATTERNS][MAX_LEN];
  logic [LENW-1:0]   len_q [PATTERNS];
  logic [BYTE_W-1:0] win_q [MAX_LEN];
  logic [IDXW-1:0]   lnum_q [MAX_LEN];
  logic [BYTE_W-1:0] win_fold [MAX_LEN];

  logic [LENW-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] line_q, line_d;
  logic             seg_q, seg_d;
  logic             done_q, done_d;

  // compare stage
  logic                 stage_valid_q, stage_valid_d;
  logic                 stage_scan_q, stage_scan_d;
  logic                 stage_bound_q;
  mpbm_pkg::scan_info_t stage_info_q;

  logic                accept;
  logic                stage_drain;
  logic                is_scan;
  logic                boundary;
  logic                single;
  logic                suppressed;
  logic [PATTERNS-1:0] raw_hits;

  assign accept      = item_i.valid && item_i.ready;
  assign stage_drain = stage_valid_q && q_ready_i;
  assign item_i.ready = !stage_valid_q || q_ready_i;
  assign is_scan     = (item_i.op == mpbm_pkg::OP_SCAN);
  assign boundary    = (item_i.value < mpbm_pkg::CHAR_SPACE) &&
                       (item_i.value != mpbm_pkg::CHAR_TAB) &&
                       (item_i.value != mpbm_pkg::CHAR_NUL);

  // counters and stage control
  always_comb begin
    fill_d        = fill_q;
    seen_d        = seen_q;
    line_d        = line_q;
    stage_valid_d = stage_valid_q && !stage_drain;
    stage_scan_d  = stage_scan_q;
    if (accept) begin
      unique case (item_i.op)
        mpbm_pkg::OP_SCAN: begin
          fill_d        = (fill_q < LENW'(MAX_LEN)) ? fill_q + LENW'(1) : fill_q;
          seen_d        = seen_q + CNT_W'(1);
          line_d        = (item_i.value == mpbm_pkg::CHAR_NL) ? line_q + CNT_W'(1) : line_q;
          stage_valid_d = 1'b1;
          stage_scan_d  = 1'b1;
        end
        mpbm_pkg::OP_NEW_BUF: begin
          fill_d        = '0;
          seen_d        = '0;
          line_d        = mpbm_pkg::LINE_FIRST;
          stage_valid_d = 1'b1;
          stage_scan_d  = 1'b0;
        end
        mpbm_pkg::OP_LOAD_BYTE, mpbm_pkg::OP_SET_LEN: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      seen_q        <= '0;
      line_q        <= mpbm_pkg::LINE_FIRST;
      seg_q         <= 1'b0;
      done_q        <= 1'b0;
      stage_valid_q <= 1'b0;
      stage_scan_q  <= 1'b0;
    end else begin
      fill_q        <= fill_d;
      seen_q        <= seen_d;
      line_q        <= line_d;
      seg_q         <= seg_d;
      done_q        <= done_d;
      stage_valid_q <= stage_valid_d;
      stage_scan_q  <= stage_scan_d;
    end
  end

  // lengths reset to zero, so every pattern starts disabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PATTERNS; p++) begin
        len_q[p] <= '0;
      end
    end else if (accept && item_i.op == mpbm_pkg::OP_SET_LEN) begin
      for (int p = 0; p < PATTERNS; p++) begin
        if (int'(item_i.pattern_slot) == p) begin
          len_q[p] <= ({1'b0, item_i.value} > (BYTE_W + 1)'(MAX_LEN)) ?
                      LENW'(MAX_LEN) : LENW'(item_i.value);
        end
      end
    end
  end

  // pattern bytes, window and line tags carry no reset
  always_ff @(posedge clk_i) begin
    if (accept && item_i.op == mpbm_pkg::OP_LOAD_BYTE) begin
      for (int p = 0; p < PATTERNS; p++) begin
        for (int j = 0; j < MAX_LEN; j++) begin
          if (int'(item_i.pattern_slot) == p && int'(item_i.byte_position) == j) begin
            pat_q[p][j] <= item_i.value;
          end
        end
      end
    end
    if (accept && is_scan) begin
      for (int k = MAX_LEN - 1; k > 0; k--) begin
        win_q[k]  <= win_q[k-1];
        lnum_q[k] <= lnum_q[k-1];
      end
      win_q[0]  <= item_i.value;
      lnum_q[0] <= line_q[IDXW-1:0];
    end
    if (accept) begin
      stage_info_q  <= '{offset: seen_q, line: line_q};
      stage_bound_q <= boundary;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_LEN; k++) begin
      win_fold[k] = fold(win_q[k], case_sensitive_i);
    end
  end

  // pattern byte j lines up with the byte len-1-j places back
  always_comb begin
    logic            match;
    logic [IDXW-1:0] sel;
    match = 1'b0;
    sel   = '0;
    for (int p = 0; p < PATTERNS; p++) begin
      match = (len_q[p] != '0) && (len_q[p] <= fill_q);
      for (int j = 0; j < MAX_LEN; j++) begin
        if (LENW'(j) < len_q[p]) begin
          sel = IDXW'(len_q[p] - LENW'(j) - LENW'(1));
          if (fold(pat_q[p][j], case_sensitive_i) != win_fold[sel]) begin
            match = 1'b0;
          end
        end
      end
      raw_hits[p] = match;
      // newlines between match start and the current byte, modulo the tag range
      push_nl_o[p] = '0;
      if (len_q[p] != '0) begin
        sel          = IDXW'(len_q[p] - LENW'(1));
        push_nl_o[p] = lnum_q[0] - lnum_q[sel];
      end
      push_len_o[p] = len_q[p];
    end
  end

  assign single     = (report_mode_i == mpbm_pkg::MODE_SEGMENT) ||
                      (report_mode_i == mpbm_pkg::MODE_FIRST);
  assign suppressed = ((report_mode_i == mpbm_pkg::MODE_SEGMENT) && seg_q) ||
                      ((report_mode_i == mpbm_pkg::MODE_FIRST) && done_q);

  always_comb begin
    if (suppressed) begin
      push_hits_o = '0;
    end else if (single) begin
      push_hits_o = raw_hits & (~raw_hits + PATTERNS'(1));
    end else begin
      push_hits_o = raw_hits;
    end
  end

  assign push_valid_o = stage_valid_q && stage_scan_q && (push_hits_o != '0);
  assign push_info_o  = stage_info_q;

  // suppression flags move in item order with the compare stage
  always_comb begin
    seg_d  = seg_q;
    done_d = done_q;
    if (stage_drain) begin
      if (stage_scan_q) begin
        seg_d  = stage_bound_q ? 1'b0 :
                 (seg_q || ((report_mode_i == mpbm_pkg::MODE_SEGMENT) && (raw_hits != '0)));
        done_d = done_q || ((report_mode_i == mpbm_pkg::MODE_FIRST) && (raw_hits != '0));
      end else begin
        seg_d  = 1'b0;
        done_d = 1'b0;
      end
    end
  end

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && single) |-> $onehot(push_hits_o))
    else $error("more than one hit pushed in a single-report mode");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LENW'(MAX_LEN))
    else $error("window fill count beyond window size");

endmodule

>>> rtl/core/mpbm_queue.sv
// short first-in first-out queue between front and back end
// standalone, depends on nothing but its parameters
module mpbm_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             do_push;

  assign push_ready_o = (count_q != CNTW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
      end
      if (do_push && !pop_i) begin
        count_q <= count_q + CNTW'(1);
      end else if (!do_push && pop_i) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

endmodule

>>> rtl/core/mpbm_back.sv
// back end: walks the hit vector of one queued byte, lowest pattern first,
// and drives one result transfer per cycle while result_o.ready is high; uses mpbm_pkg, mpbm_if
module mpbm_back #(
  parameter int unsigned PATTERNS = mpbm_pkg::PATTERNS_DEF,
  parameter int unsigned MAX_LEN  = mpbm_pkg::MAX_LEN_DEF,
  localparam int unsigned LENW    = mpbm_pkg::len_width(MAX_LEN),
  localparam int unsigned IDXW    = mpbm_pkg::idx_width(MAX_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  logic [PATTERNS-1:0]               q_hits_i,
  input  logic [PATTERNS-1:0][LENW-1:0]     q_len_i,
  input  logic [PATTERNS-1:0][IDXW-1:0]     q_nl_i,
  input  mpbm_pkg::scan_info_t              q_info_i,
  mpbm_out_if.source                        result_o
);

  localparam int unsigned PW    = mpbm_pkg::pat_width(PATTERNS);
  localparam int unsigned CNT_W = mpbm_pkg::CNT_W;
  localparam int unsigned HIT_W = mpbm_pkg::HIT_W;
  localparam int unsigned RCW   = mpbm_pkg::RES_CNT_W;

  logic                          cur_valid_q, cur_valid_d;
  logic [PATTERNS-1:0]           cur_rem_q, cur_rem_d;
  logic [RCW-1:0]                cur_cnt_q, cur_cnt_d;
  logic [PATTERNS-1:0][LENW-1:0] cur_len_q;
  logic [PATTERNS-1:0][IDXW-1:0] cur_nl_q;
  mpbm_pkg::scan_info_t          cur_info_q;

  logic             out_valid_q;
  logic [HIT_W-1:0] out_hit_q;
  logic [CNT_W-1:0] out_off_q;
  logic [CNT_W-1:0] out_line_q;
  logic             out_last_q;

  logic [PW-1:0]       pick;
  logic [PATTERNS-1:0] rem_next;
  logic                last;
  logic                out_free;
  logic                emit;
  logic                load_cur;

  always_comb begin
    logic found;
    found = 1'b0;
    pick  = '0;
    for (int p = 0; p < PATTERNS; p++) begin
      if (!found && cur_rem_q[p]) begin
        pick  = PW'(p);
        found = 1'b1;
      end
    end
  end

  assign rem_next = cur_rem_q & (cur_rem_q - PATTERNS'(1));
  assign last     = (rem_next == '0) ||
                    (cur_cnt_q == RCW'(mpbm_pkg::MAX_RESULTS - 1));
  assign out_free = !out_valid_q || result_o.ready;
  assign emit     = cur_valid_q && out_free;
  assign load_cur = q_valid_i && (!cur_valid_q || (emit && last));
  assign q_pop_o  = load_cur;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_rem_d   = cur_rem_q;
    cur_cnt_d   = cur_cnt_q;
    if (emit) begin
      cur_rem_d = rem_next;
      cur_cnt_d = cur_cnt_q + RCW'(1);
      if (last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (load_cur) begin
      cur_valid_d = 1'b1;
      cur_rem_d   = q_hits_i;
      cur_cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_rem_q   <= '0;
      cur_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cur_rem_q   <= cur_rem_d;
      cur_cnt_q   <= cur_cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cur) begin
      cur_len_q  <= q_len_i;
      cur_nl_q   <= q_nl_i;
      cur_info_q <= q_info_i;
    end
    if (emit) begin
      out_hit_q  <= HIT_W'(pick);
      out_off_q  <= cur_info_q.offset + CNT_W'(1) - CNT_W'(cur_len_q[pick]);
      out_line_q <= cur_info_q.line - CNT_W'(cur_nl_q[pick]);
      out_last_q <= last;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.pattern_hit  = out_hit_q;
  assign result_o.start_offset = out_off_q;
  assign result_o.line_number  = out_line_q;
  assign result_o.last_of_run  = out_last_q;

  a_cur_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_rem_q != '0))
    else $error("working entry holds no hit");

  a_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (out_valid_q && out_last_q))
    else $error("run ended without last_of_run on its final result");

endmodule

>>> rtl/core/multi_pattern_byte_matcher_core.sv
// top level of the multi-pattern byte matcher: configuration registers,
// front end, hit queue and back end; uses mpbm_pkg, mpbm_if and the mpbm_* modules
//
//   channel   role     transfer carries
//   item_i    sink     op, pattern_slot, byte_position, value
//   result_o  source   pattern_hit, start_offset, line_number, last_of_run
//   cfg_*     write    cfg_idx_i selects case_sensitive (0) or report_mode (1)
//
// input: one input transfer per clock while item_i.ready is high; a scanned byte is compared
//   against all patterns in the cycle after its transfer and its hits enter a two-entry queue
// output: the back end sends one result per clock while result_o is ready, one per hit
//   up to MAX_RESULTS per byte; the input stalls only once the queue is full
// reset: asynchronous, no clearing pass; all pattern lengths read zero at once
//   and pattern bytes are undefined until loaded
// stalls: the output register is freed on the same edge its result is taken
module multi_pattern_byte_matcher_core #(
  parameter int unsigned PATTERNS = mpbm_pkg::PATTERNS_DEF,
  parameter int unsigned MAX_LEN  = mpbm_pkg::MAX_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mpbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mpbm_in_if.sink                           item_i,
  mpbm_out_if.source                        result_o
);

  localparam int unsigned LENW    = mpbm_pkg::len_width(MAX_LEN);
  localparam int unsigned IDXW    = mpbm_pkg::idx_width(MAX_LEN);
  localparam int unsigned INFO_W  = $bits(mpbm_pkg::scan_info_t);
  // queue entry: hit vector, lengths and newline counts per pattern, counters
  localparam int unsigned ENTRY_W = PATTERNS + PATTERNS * LENW + PATTERNS * IDXW + INFO_W;

  // configuration registers, to be written only while the block is idle; the block does not enforce this
  logic                          case_sens_q;
  logic [mpbm_pkg::MODE_W-1:0]   report_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_sens_q   <= 1'b0;
      report_mode_q <= mpbm_pkg::MODE_EVERY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mpbm_pkg::CFG_CASE_SENSITIVE: case_sens_q   <= cfg_data_i[0];
        mpbm_pkg::CFG_REPORT_MODE:    report_mode_q <= cfg_data_i;
      endcase
    end
  end

  // front end to queue
  logic                          push_valid;
  logic                          push_ready;
  logic [PATTERNS-1:0]           push_hits;
  logic [PATTERNS-1:0][LENW-1:0] push_len;
  logic [PATTERNS-1:0][IDXW-1:0] push_nl;
  mpbm_pkg::scan_info_t          push_info;
  logic [ENTRY_W-1:0]            push_data;

  // queue to back end
  logic                          pop_valid;
  logic                          pop;
  logic [ENTRY_W-1:0]            pop_data;
  logic [PATTERNS-1:0]           pop_hits;
  logic [PATTERNS-1:0][LENW-1:0] pop_len;
  logic [PATTERNS-1:0][IDXW-1:0] pop_nl;
  mpbm_pkg::scan_info_t          pop_info;

  mpbm_front #(
    .PATTERNS (PATTERNS),
    .MAX_LEN  (MAX_LEN)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .case_sensitive_i (case_sens_q),
    .report_mode_i    (report_mode_q),
    .item_i           (item_i),
    .q_ready_i        (push_ready),
    .push_valid_o     (push_valid),
    .push_hits_o      (push_hits),
    .push_len_o       (push_len),
    .push_nl_o        (push_nl),
    .push_info_o      (push_info)
  );

  assign push_data = {push_hits, push_len, push_nl, push_info};

  mpbm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (mpbm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  assign {pop_hits, pop_len, pop_nl, pop_info} = pop_data;

  mpbm_back #(
    .PATTERNS (PATTERNS),
    .MAX_LEN  (MAX_LEN)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_pop_o   (pop),
    .q_hits_i  (pop_hits),
    .q_len_i   (pop_len),
    .q_nl_i    (pop_nl),
    .q_info_i  (pop_info),
    .result_o  (result_o)
  );

endmodule
